// ===== rtl/multi_frame_detection_persistence_assert.svh =====
// ----------------------------------------------------------------------------
// multi frame detection persistence assertion macros
// property wrappers used by mfdp_back
// ----------------------------------------------------------------------------
`ifndef MULTI_FRAME_DETECTION_PERSISTENCE_ASSERT_SVH
`define MULTI_FRAME_DETECTION_PERSISTENCE_ASSERT_SVH

`ifndef SYNTHESIS
`define MFDP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MFDP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MFDP_ASSERT(label, clk, rst_n, prop, msg)
`define MFDP_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/mfdp_pkg.sv =====
// ----------------------------------------------------------------------------
// mfdp_pkg
// types and constants of the detection persistence filter
// ----------------------------------------------------------------------------
`default_nettype none
package mfdp_pkg;

  localparam int unsigned HISTORY_FRAMES_DEF = 8;
  localparam int unsigned MAX_PER_FRAME_DEF  = 32;
  localparam int unsigned RESULT_CAP         = 32;
  localparam int unsigned SLOT_W             = 4;
  localparam int unsigned FILL_W             = 7;
  localparam int unsigned HELD_W             = 5;
  localparam int unsigned CNT_W              = 6;

  localparam logic [15:0] RADIUS_RST   = 16'd500;
  localparam logic [3:0]  MIN_SIGHT_RST = 4'd3;

  localparam logic REG_RADIUS   = 1'b0;
  localparam logic REG_MIN_SIGHT = 1'b1;

  localparam logic [2:0] CAT_UNKNOWN = 3'd4;
  localparam logic [2:0] CLS_KNOWN_MAX = 3'd3;

  typedef struct packed {
    logic signed [15:0] pos_x_mm;
    logic signed [15:0] pos_y_mm;
    logic [2:0]         object_class;
    logic               item_valid;
    logic               frame_end;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] out_x_mm;
    logic signed [15:0] out_y_mm;
    logic [2:0]         out_category;
    logic               present;
    logic               last_of_frame;
    logic               overflow;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [2:0]         cls;
  } ring_entry_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [FILL_W-1:0] fill;
    logic [HELD_W-1:0] held;
    logic              ovf;
  } close_cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_CAND,
    BK_CAND_W,
    BK_SLOT,
    BK_ENT,
    BK_ENT_W,
    BK_ENT_C,
    BK_DECIDE,
    BK_FINISH
  } back_state_e;

endpackage
`default_nettype wire

// ===== rtl/multi_frame_detection_persistence.sv =====
// ----------------------------------------------------------------------------
// multi_frame_detection_persistence
// persistence filter over a ring of recent detection frames
// ----------------------------------------------------------------------------
// a word that does not end a frame does not raise busy
// a frame end raises busy until the scan of the closed frame ends; the scan covers the
//   stored words until the result cap is reached and compares each with the entries of
//   the held frames through the single read port of the detection store
// results leave as one-cycle strobes during the scan, the last word in the cycle after it ends
// reset clears fill counts, ring pointers and config to 500 mm and 3 sightings
`default_nettype none
module multi_frame_detection_persistence #(
  parameter int unsigned HISTORY_FRAMES = mfdp_pkg::HISTORY_FRAMES_DEF,
  parameter int unsigned MAX_PER_FRAME  = mfdp_pkg::MAX_PER_FRAME_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  output logic                busy,
  input  mfdp_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  output mfdp_pkg::out_word_t out_word_o,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire [2:0]           paddr,
  input  wire [31:0]          pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned DEPTH = HISTORY_FRAMES * MAX_PER_FRAME;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [15:0] radius_q;
  logic [3:0]  min_sight_q;

  logic accept;
  logic we, push, pop, cmd_full, back_busy;
  logic [AW-1:0] waddr, raddr;
  mfdp_pkg::ring_entry_t wdata, rdata;
  mfdp_pkg::close_cmd_t  cmd_in, cmd_out;
  logic [mfdp_pkg::SLOT_W-1:0] fill_slot;
  logic [mfdp_pkg::FILL_W-1:0] fill;

  assign busy   = cmd_full || back_busy;
  assign accept = start && !busy;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= mfdp_pkg::RADIUS_RST;
      min_sight_q <= mfdp_pkg::MIN_SIGHT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        mfdp_pkg::REG_RADIUS:    radius_q    <= pwdata[15:0];
        mfdp_pkg::REG_MIN_SIGHT: min_sight_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mfdp_pkg::REG_RADIUS:    prdata = {16'd0, radius_q};
      mfdp_pkg::REG_MIN_SIGHT: prdata = {28'd0, min_sight_q};
      default:                 prdata = '0;
    endcase
  end

  mfdp_front #(
    .HISTORY_FRAMES(HISTORY_FRAMES), .MAX_PER_FRAME(MAX_PER_FRAME), .AW(AW)
  ) u_front (
    .clk_i, .rst_ni, .accept_i(accept), .word_i(in_word_i),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata),
    .push_o(push), .cmd_o(cmd_in), .fill_slot_i(fill_slot), .fill_o(fill)
  );

  mfdp_ring #(.DEPTH(DEPTH), .AW(AW)) u_ring (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  mfdp_cmdq u_cmdq (
    .clk_i, .rst_ni, .push_i(push), .cmd_i(cmd_in), .pop_i(pop),
    .full_o(cmd_full), .cmd_o(cmd_out)
  );

  mfdp_back #(
    .HISTORY_FRAMES(HISTORY_FRAMES), .MAX_PER_FRAME(MAX_PER_FRAME), .AW(AW)
  ) u_back (
    .clk_i, .rst_ni, .cmd_full_i(cmd_full), .cmd_i(cmd_out), .pop_o(pop),
    .busy_o(back_busy), .fill_slot_o(fill_slot), .fill_i(fill),
    .raddr_o(raddr), .rdata_i(rdata), .radius_i(radius_q), .min_sight_i(min_sight_q),
    .out_valid_o, .out_word_o
  );

endmodule
`default_nettype wire

// ===== rtl/mfdp_ring.sv =====
// ----------------------------------------------------------------------------
// mfdp_ring
// detection store, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module mfdp_ring #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [AW-1:0]              waddr_i,
  input  mfdp_pkg::ring_entry_t     wdata_i,
  input  wire [AW-1:0]              raddr_i,
  output mfdp_pkg::ring_entry_t     rdata_o
);

  mfdp_pkg::ring_entry_t mem_q [DEPTH];
  mfdp_pkg::ring_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/mfdp_front.sv =====
// ----------------------------------------------------------------------------
// mfdp_front
// loads detections into the open slot and closes frames into commands
// ----------------------------------------------------------------------------
`default_nettype none
module mfdp_front #(
  parameter int unsigned HISTORY_FRAMES = 8,
  parameter int unsigned MAX_PER_FRAME  = 32,
  parameter int unsigned AW             = 8
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        accept_i,
  input  mfdp_pkg::in_word_t         word_i,
  output logic                       we_o,
  output logic [AW-1:0]              waddr_o,
  output mfdp_pkg::ring_entry_t      wdata_o,
  output logic                       push_o,
  output mfdp_pkg::close_cmd_t       cmd_o,
  input  wire [mfdp_pkg::SLOT_W-1:0] fill_slot_i,
  output logic [mfdp_pkg::FILL_W-1:0] fill_o
);

  localparam int unsigned SW = (HISTORY_FRAMES > 1) ? $clog2(HISTORY_FRAMES) : 1;
  localparam int unsigned FW = $clog2(MAX_PER_FRAME + 1);
  localparam int unsigned HW = $clog2(HISTORY_FRAMES + 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(HISTORY_FRAMES - 1);
  localparam logic [FW-1:0] MAX_F     = FW'(MAX_PER_FRAME);
  localparam logic [HW-1:0] HIST_H    = HW'(HISTORY_FRAMES);
  localparam logic [AW-1:0] MAX_A     = AW'(MAX_PER_FRAME);

  logic [FW-1:0] fill_q [HISTORY_FRAMES];
  logic [SW-1:0] newest_q;
  logic [HW-1:0] held_q;
  logic [FW-1:0] wc_q;
  logic          ovf_q;

  logic [SW-1:0] next_slot;
  logic          store;
  logic [FW-1:0] wc_new;
  logic          ovf_new;
  logic [HW-1:0] held_new;

  always_comb begin
    next_slot = (newest_q == LAST_SLOT) ? '0 : newest_q + SW'(1);
    store     = accept_i && word_i.item_valid && (wc_q < MAX_F);
    wc_new    = store ? wc_q + FW'(1) : wc_q;
    ovf_new   = ovf_q || (accept_i && word_i.item_valid && (wc_q >= MAX_F));
    held_new  = (held_q < HIST_H) ? held_q + HW'(1) : held_q;
  end

  assign we_o    = store;
  assign waddr_o = AW'(next_slot) * MAX_A + AW'(wc_q);
  assign wdata_o = '{x: word_i.pos_x_mm, y: word_i.pos_y_mm, cls: word_i.object_class};
  assign push_o  = accept_i && word_i.frame_end;
  assign cmd_o   = '{slot: mfdp_pkg::SLOT_W'(next_slot), fill: mfdp_pkg::FILL_W'(wc_new),
                     held: mfdp_pkg::HELD_W'(held_new), ovf: ovf_new};
  assign fill_o  = mfdp_pkg::FILL_W'(fill_q[fill_slot_i[SW-1:0]]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q <= '0;
      held_q   <= '0;
      wc_q     <= '0;
      ovf_q    <= 1'b0;
      for (int n = 0; n < HISTORY_FRAMES; n++) begin
        fill_q[n] <= '0;
      end
    end else if (accept_i) begin
      if (word_i.frame_end) begin
        fill_q[next_slot] <= wc_new;
        newest_q <= next_slot;
        held_q   <= held_new;
        wc_q     <= '0;
        ovf_q    <= 1'b0;
      end else begin
        wc_q  <= wc_new;
        ovf_q <= ovf_new;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mfdp_cmdq.sv =====
// ----------------------------------------------------------------------------
// mfdp_cmdq
// one-entry queue of closed frames between loader and scanner
// ----------------------------------------------------------------------------
`default_nettype none
module mfdp_cmdq (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  mfdp_pkg::close_cmd_t cmd_i,
  input  wire                  pop_i,
  output logic                 full_o,
  output mfdp_pkg::close_cmd_t cmd_o
);

  logic                 full_q;
  mfdp_pkg::close_cmd_t cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (push_i) begin
      full_q <= 1'b1;
    end else if (pop_i) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      cmd_q <= cmd_i;
    end
  end

  assign full_o = full_q;
  assign cmd_o  = cmd_q;

endmodule
`default_nettype wire

// ===== rtl/mfdp_back.sv =====
// ----------------------------------------------------------------------------
// mfdp_back
// scans a closed frame against the held frames and emits confirmed words
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_frame_detection_persistence_assert.svh"
module mfdp_back #(
  parameter int unsigned HISTORY_FRAMES = 8,
  parameter int unsigned MAX_PER_FRAME  = 32,
  parameter int unsigned AW             = 8
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cmd_full_i,
  input  mfdp_pkg::close_cmd_t        cmd_i,
  output logic                        pop_o,
  output logic                        busy_o,
  output logic [mfdp_pkg::SLOT_W-1:0] fill_slot_o,
  input  wire [mfdp_pkg::FILL_W-1:0]  fill_i,
  output logic [AW-1:0]               raddr_o,
  input  mfdp_pkg::ring_entry_t       rdata_i,
  input  wire [15:0]                  radius_i,
  input  wire [3:0]                   min_sight_i,
  output logic                        out_valid_o,
  output mfdp_pkg::out_word_t         out_word_o
);

  localparam int unsigned SW = (HISTORY_FRAMES > 1) ? $clog2(HISTORY_FRAMES) : 1;
  localparam int unsigned FW = $clog2(MAX_PER_FRAME + 1);
  localparam int unsigned HW = $clog2(HISTORY_FRAMES + 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(HISTORY_FRAMES - 1);
  localparam logic [AW-1:0] MAX_A     = AW'(MAX_PER_FRAME);
  localparam logic [mfdp_pkg::CNT_W-1:0] CAP = mfdp_pkg::CNT_W'(mfdp_pkg::RESULT_CAP);

  mfdp_pkg::back_state_e state_q, state_d;

  logic [SW-1:0] cur_q, s_q;
  logic [FW-1:0] fill_cur_q, fill_s_q, i_q, j_q;
  logic [HW-1:0] held_q, k_q, count_q;
  logic          ovf_q;
  logic [mfdp_pkg::CNT_W-1:0] nconf_q;
  mfdp_pkg::ring_entry_t cand_q;
  logic          pend_q;
  mfdp_pkg::ring_entry_t pend_e_q;
  logic [31:0]   r2_q, dx2_q, dy2_q;
  logic          cls_eq_q;
  logic          out_valid_q;
  mfdp_pkg::out_word_t out_q;

  logic signed [16:0] dx, dy;
  logic signed [33:0] dx_sq, dy_sq;
  logic [32:0]   dist2;
  logic          hit;
  logic          confirm;
  logic [2:0]    pend_cat;

  always_comb begin
    dx       = 17'(cand_q.x) - 17'(rdata_i.x);
    dy       = 17'(cand_q.y) - 17'(rdata_i.y);
    dx_sq    = 34'(dx) * 34'(dx);
    dy_sq    = 34'(dy) * 34'(dy);
    dist2    = 33'(dx2_q) + 33'(dy2_q);
    hit      = cls_eq_q && (dist2 < {1'b0, r2_q});
    confirm  = {{(8-HW){1'b0}}, count_q} >= {4'd0, min_sight_i};
    pend_cat = (pend_e_q.cls <= mfdp_pkg::CLS_KNOWN_MAX) ? pend_e_q.cls : mfdp_pkg::CAT_UNKNOWN;
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    raddr_o = AW'(cur_q) * MAX_A + AW'(i_q);
    unique case (state_q)
      mfdp_pkg::BK_IDLE: begin
        if (cmd_full_i) begin
          pop_o   = 1'b1;
          state_d = mfdp_pkg::BK_CAND;
        end
      end
      mfdp_pkg::BK_CAND: begin
        if (i_q == fill_cur_q || nconf_q == CAP) begin
          state_d = mfdp_pkg::BK_FINISH;
        end else begin
          state_d = mfdp_pkg::BK_CAND_W;
        end
      end
      mfdp_pkg::BK_CAND_W: state_d = mfdp_pkg::BK_SLOT;
      mfdp_pkg::BK_SLOT: begin
        state_d = (k_q == held_q) ? mfdp_pkg::BK_DECIDE : mfdp_pkg::BK_ENT;
      end
      mfdp_pkg::BK_ENT: begin
        raddr_o = AW'(s_q) * MAX_A + AW'(j_q);
        state_d = (j_q == fill_s_q) ? mfdp_pkg::BK_SLOT : mfdp_pkg::BK_ENT_W;
      end
      mfdp_pkg::BK_ENT_W: state_d = mfdp_pkg::BK_ENT_C;
      mfdp_pkg::BK_ENT_C: state_d = hit ? mfdp_pkg::BK_SLOT : mfdp_pkg::BK_ENT;
      mfdp_pkg::BK_DECIDE: state_d = mfdp_pkg::BK_CAND;
      mfdp_pkg::BK_FINISH: state_d = mfdp_pkg::BK_IDLE;
      default: state_d = mfdp_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfdp_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= 1'b0;
      unique case (state_q)
        mfdp_pkg::BK_IDLE: pend_q <= 1'b0;
        mfdp_pkg::BK_DECIDE: begin
          if (confirm) begin
            out_valid_q <= pend_q;
            pend_q      <= 1'b1;
          end
        end
        mfdp_pkg::BK_FINISH: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    r2_q     <= 32'(radius_i) * 32'(radius_i);
    dx2_q    <= dx_sq[31:0];
    dy2_q    <= dy_sq[31:0];
    cls_eq_q <= (cand_q.cls == rdata_i.cls);
    unique case (state_q)
      mfdp_pkg::BK_IDLE: begin
        cur_q      <= cmd_i.slot[SW-1:0];
        fill_cur_q <= cmd_i.fill[FW-1:0];
        held_q     <= cmd_i.held[HW-1:0];
        ovf_q      <= cmd_i.ovf;
        i_q        <= '0;
        nconf_q    <= '0;
      end
      mfdp_pkg::BK_CAND_W: begin
        cand_q  <= rdata_i;
        k_q     <= '0;
        count_q <= '0;
        s_q     <= cur_q;
        j_q     <= '0;
        fill_s_q <= fill_i[FW-1:0];
      end
      mfdp_pkg::BK_ENT: begin
        if (j_q == fill_s_q) begin
          k_q <= k_q + HW'(1);
          s_q <= (s_q == '0) ? LAST_SLOT : s_q - SW'(1);
        end
      end
      mfdp_pkg::BK_SLOT: begin
        j_q      <= '0;
        fill_s_q <= fill_i[FW-1:0];
      end
      mfdp_pkg::BK_ENT_C: begin
        if (hit) begin
          count_q <= count_q + HW'(1);
          k_q     <= k_q + HW'(1);
          s_q     <= (s_q == '0) ? LAST_SLOT : s_q - SW'(1);
        end else begin
          j_q <= j_q + FW'(1);
        end
      end
      mfdp_pkg::BK_DECIDE: begin
        i_q <= i_q + FW'(1);
        if (confirm) begin
          nconf_q  <= nconf_q + mfdp_pkg::CNT_W'(1);
          pend_e_q <= cand_q;
          out_q    <= '{out_x_mm: pend_e_q.x, out_y_mm: pend_e_q.y, out_category: pend_cat,
                        present: 1'b1, last_of_frame: 1'b0, overflow: ovf_q};
        end
      end
      mfdp_pkg::BK_FINISH: begin
        if (pend_q) begin
          out_q <= '{out_x_mm: pend_e_q.x, out_y_mm: pend_e_q.y, out_category: pend_cat,
                     present: 1'b1, last_of_frame: 1'b1, overflow: ovf_q};
        end else begin
          out_q <= '{out_x_mm: '0, out_y_mm: '0, out_category: '0,
                     present: 1'b0, last_of_frame: 1'b1, overflow: ovf_q};
        end
      end
      default: ;
    endcase
  end

  assign fill_slot_o = mfdp_pkg::SLOT_W'(s_q);
  assign busy_o      = (state_q != mfdp_pkg::BK_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `MFDP_ASSERT(a_finish_emits, clk_i, rst_ni, state_q == mfdp_pkg::BK_FINISH |=> out_valid_o && out_word_o.last_of_frame, "frame end without last word")
  `MFDP_ASSERT(a_pop_idle, clk_i, rst_ni, pop_o |-> state_q == mfdp_pkg::BK_IDLE && cmd_full_i, "pop while scanning")
  `MFDP_ASSERT_NEVER(a_count_held, clk_i, rst_ni, state_q == mfdp_pkg::BK_DECIDE && count_q > held_q, "sightings exceed held frames")
  `MFDP_ASSERT_NEVER(a_cap, clk_i, rst_ni, state_q != mfdp_pkg::BK_IDLE && nconf_q > CAP, "result cap exceeded")

endmodule
`default_nettype wire

// ===== dv/tb_multi_frame_detection_persistence.sv =====
// ----------------------------------------------------------------------------
// tb_multi_frame_detection_persistence
// drives detection words into the persistence filter, predicts the confirmed
// detections of every closed frame and compares each output word in order
// ----------------------------------------------------------------------------
`default_nettype none
module tb_multi_frame_detection_persistence;

  localparam int HIST = mfdp_pkg::HISTORY_FRAMES_DEF;
  localparam int PER_FRAME = mfdp_pkg::MAX_PER_FRAME_DEF;
  localparam int BUF_DEPTH = 2048;
  localparam logic [2:0] ADDR_RADIUS = 3'd0;
  localparam logic [2:0] ADDR_MIN_SIGHT = 3'd4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  mfdp_pkg::in_word_t in_word = '0;
  logic out_valid;
  mfdp_pkg::out_word_t out_word;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  multi_frame_detection_persistence DUT (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy),
    .in_word_i(in_word), .out_valid_o(out_valid), .out_word_o(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic signed [15:0] hist_x [HIST][PER_FRAME];
  logic signed [15:0] hist_y [HIST][PER_FRAME];
  logic [2:0] hist_cls [HIST][PER_FRAME];
  int hist_fill [HIST];
  int newest, held, loaded;
  bit ovf_open;
  logic [15:0] radius;
  logic [3:0] min_sight;

  mfdp_pkg::in_word_t pend_words [BUF_DEPTH];
  int pend_head = 0;
  int pend_tail = 0;
  mfdp_pkg::out_word_t exp_words [BUF_DEPTH];
  int exp_head = 0;
  int exp_tail = 0;
  int fails = 0;
  int shown = 0;
  bit took = 1'b0;

  function automatic longint sq(logic signed [15:0] a, logic signed [15:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return d * d;
  endfunction

  function automatic bit frame_matches(int s, logic signed [15:0] x, logic signed [15:0] y,
                                       logic [2:0] c, longint r2);
    for (int i = 0; i < hist_fill[s]; i++)
      if (hist_cls[s][i] == c && sq(x, hist_x[s][i]) + sq(y, hist_y[s][i]) < r2)
        return 1'b1;
    return 1'b0;
  endfunction

  task automatic add_pending(mfdp_pkg::in_word_t w);
    pend_words[pend_tail] = w;
    pend_tail++;
  endtask

  task automatic add_expected(mfdp_pkg::out_word_t o);
    exp_words[exp_tail] = o;
    exp_tail++;
  endtask

  task automatic predict_word(mfdp_pkg::in_word_t w);
    int nxt, cnt, emitted;
    longint r2;
    mfdp_pkg::out_word_t o;
    nxt = (newest + 1) % HIST;
    if (w.item_valid) begin
      if (loaded < PER_FRAME) begin
        hist_x[nxt][loaded] = w.pos_x_mm;
        hist_y[nxt][loaded] = w.pos_y_mm;
        hist_cls[nxt][loaded] = w.object_class;
        loaded++;
      end else ovf_open = 1'b1;
    end
    if (!w.frame_end) return;
    newest = nxt;
    hist_fill[nxt] = loaded;
    if (held < HIST) held++;
    r2 = longint'(radius) * longint'(radius);
    emitted = 0;
    for (int i = 0; i < hist_fill[nxt]; i++) begin
      if (emitted >= mfdp_pkg::RESULT_CAP) break;
      cnt = 0;
      for (int k = 0; k < held; k++)
        if (frame_matches((nxt + HIST - k) % HIST, hist_x[nxt][i], hist_y[nxt][i],
                          hist_cls[nxt][i], r2)) cnt++;
      if (cnt < min_sight) continue;
      o.out_x_mm = hist_x[nxt][i];
      o.out_y_mm = hist_y[nxt][i];
      o.out_category = (hist_cls[nxt][i] <= mfdp_pkg::CLS_KNOWN_MAX) ?
                       hist_cls[nxt][i] : mfdp_pkg::CAT_UNKNOWN;
      o.present = 1'b1;
      o.last_of_frame = 1'b0;
      o.overflow = ovf_open;
      add_expected(o);
      emitted++;
    end
    if (emitted == 0) begin
      o = '0;
      o.last_of_frame = 1'b1;
      o.overflow = ovf_open;
      add_expected(o);
    end else exp_words[exp_tail - 1].last_of_frame = 1'b1;
    loaded = 0;
    ovf_open = 1'b0;
  endtask

  // driver
  int gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (took) begin
        pend_head++;
        gap = int'($urandom_range(0, 5));
        if ($urandom_range(0, 2) == 0) gap = 0;
      end
      if (start && !took) begin
        // word still waiting on busy
      end else if (pend_head < pend_tail && gap > 0) begin
        start <= 1'b0;
        gap = gap - 1;
      end else if (pend_head < pend_tail) begin
        start <= 1'b1;
        in_word <= pend_words[pend_head];
      end else start <= 1'b0;
    end
  end

  // accepted input words feed the predictor
  always @(posedge clk) begin
    took = rst_n && start && !busy;
    if (took) predict_word(in_word);
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (exp_head == exp_tail) begin
        fails++;
        if (shown < 10) begin
          shown++;
          $display("unexpected word %h", out_word);
        end
      end else begin
        if (out_word !== exp_words[exp_head]) begin
          fails++;
          if (shown < 10) begin
            shown++;
            $display("mismatch: expected %h actual %h", exp_words[exp_head], out_word);
          end
        end
        exp_head++;
      end
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_RADIUS) radius = val[15:0];
    else if (addr == ADDR_MIN_SIGHT) min_sight = val[3:0];
  endtask

  task automatic wait_drained();
    while (pend_head < pend_tail || exp_head < exp_tail) @(posedge clk);
    repeat (40) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic mfdp_pkg::in_word_t rand_det(bit ends);
    mfdp_pkg::in_word_t w;
    w.pos_x_mm = 16'($urandom);
    w.pos_y_mm = 16'($urandom);
    w.object_class = 3'($urandom_range(0, 7));
    w.item_valid = ($urandom_range(0, 9) != 0);
    w.frame_end = ends;
    return w;
  endfunction

  // a small set of anchors keeps detections persistent across frames
  logic signed [15:0] anchor_x [6];
  logic signed [15:0] anchor_y [6];
  logic [2:0] anchor_c [6];

  task automatic queue_frame(int n, int spread);
    mfdp_pkg::in_word_t w;
    int a;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) w = rand_det(1'b0);
      else begin
        a = int'($urandom_range(0, 5));
        w.pos_x_mm = 16'(anchor_x[a] + $signed(16'($urandom_range(0, 2 * spread))) - spread);
        w.pos_y_mm = 16'(anchor_y[a] + $signed(16'($urandom_range(0, 2 * spread))) - spread);
        w.object_class = anchor_c[a];
        w.item_valid = ($urandom_range(0, 15) != 0);
        w.frame_end = 1'b0;
      end
      if (i == n - 1) w.frame_end = 1'b1;
      add_pending(w);
    end
  endtask

  initial begin
    mfdp_pkg::in_word_t w;
    int n;
    for (int s = 0; s < HIST; s++) hist_fill[s] = 0;
    newest = 0; held = 0; loaded = 0; ovf_open = 1'b0;
    radius = 16'd500; min_sight = 4'd3;
    for (int a = 0; a < 6; a++) begin
      anchor_x[a] = 16'($urandom); anchor_y[a] = 16'($urandom);
      anchor_c[a] = 3'($urandom_range(0, 7));
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, skipped frame end, empty frame, repeated frames
    reg_write(ADDR_MIN_SIGHT, 32'd1);
    w = '0; w.frame_end = 1'b1; add_pending(w);
    w.item_valid = 1'b1; w.pos_x_mm = 16'sh7fff; w.pos_y_mm = 16'sh8000;
    w.object_class = 3'd7; w.frame_end = 1'b0; add_pending(w);
    w.pos_x_mm = 16'sh8000; w.pos_y_mm = 16'sh7fff; w.object_class = 3'd4;
    add_pending(w);
    for (int c = 0; c < 4; c++) begin
      w.pos_x_mm = 16'(c * 100); w.pos_y_mm = -16'(c * 100); w.object_class = 3'(c);
      add_pending(w);
    end
    w.item_valid = 1'b0; w.frame_end = 1'b1; add_pending(w);
    for (int f = 0; f < 3; f++) begin
      w = '0; w.item_valid = 1'b1; w.pos_x_mm = 16'sd10; w.object_class = 3'd2;
      w.pos_y_mm = 16'(f * 50); w.frame_end = 1'b1;
      add_pending(w);
    end
    wait_drained();

    // overflow frame with every result emitted
    reg_write(ADDR_RADIUS, 32'd65535);
    reg_write(ADDR_MIN_SIGHT, 32'd0);
    for (int i = 0; i < 36; i++) begin
      w = rand_det(i == 35); w.item_valid = 1'b1;
      add_pending(w);
    end
    wait_drained();
    reg_write(ADDR_RADIUS, 32'd0);
    queue_frame(4, 10);
    wait_drained();

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin reg_write(ADDR_RADIUS, 32'd500); reg_write(ADDR_MIN_SIGHT, 32'd3); end
        1: begin reg_write(ADDR_RADIUS, 32'd2000); reg_write(ADDR_MIN_SIGHT, 32'd8); end
        2: begin reg_write(ADDR_RADIUS, 32'd300); reg_write(ADDR_MIN_SIGHT, 32'd15); end
        3: begin reg_write(ADDR_RADIUS, 32'hffffffff); reg_write(ADDR_MIN_SIGHT, 32'd2); end
        4: begin reg_write(ADDR_RADIUS, 32'd1); reg_write(ADDR_MIN_SIGHT, 32'd1); end
        default: begin reg_write(ADDR_RADIUS, $urandom_range(50, 5000));
                 reg_write(ADDR_MIN_SIGHT, $urandom_range(1, 8)); end
      endcase
      n = 0;
      while (n < 72) begin
        int len;
        len = ($urandom_range(0, 20) == 0) ? int'($urandom_range(30, 36)) :
                                             int'($urandom_range(1, 8));
        queue_frame(len, int'($urandom_range(0, 600)));
        n += len;
      end
      wait_drained();
    end

    if (fails == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
